@@ rtl/board_interrupt_glue_registers_core_defines.svh @@
// ----------------------------------------------------------------------------
// Board interrupt glue assertion macros
// Concurrent check wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef BOARD_INTERRUPT_GLUE_REGISTERS_CORE_DEFINES_SVH
`define BOARD_INTERRUPT_GLUE_REGISTERS_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define BIGR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bigr: same-cycle check failed");
`define BIGR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bigr: next-cycle check failed");
`else
`define BIGR_ASSERT_NOW(label, ante, cons)
`define BIGR_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ rtl/bigr_pkg.sv @@
// ----------------------------------------------------------------------------
// Board interrupt glue package
// Widths, command codes, port addresses, signal codes and the line mapping.
// ----------------------------------------------------------------------------
package bigr_pkg;

    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int SIG_ID_W   = 5;
    localparam int FLAGS_W    = 16;
    localparam int MISC_W     = 3;
    localparam int S_TDATA_W  = 40;
    localparam int M_TDATA_W  = 16;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [SIG_ID_W-1:0] sig_id_t;

    localparam cmd_t CMD_WRITE  = 2'd0;
    localparam cmd_t CMD_READ   = 2'd1;
    localparam cmd_t CMD_SIGNAL = 2'd2;

    localparam addr_t PORT_IRQ_EN     = 16'hfd02;
    localparam addr_t PORT_IRQ_STAT   = 16'hfd03;
    localparam addr_t PORT_FIRQ_STAT  = 16'hfd04;
    localparam addr_t PORT_BUSY       = 16'hfd05;
    localparam addr_t PORT_DIRECT     = 16'hfd0f;
    localparam addr_t PORT_RTC        = 16'hfd10;
    localparam addr_t PORT_SIDE_2D    = 16'hfd1c;
    localparam addr_t PORT_DRIVE_2D   = 16'hfd1d;
    localparam addr_t PORT_STAT_2D    = 16'hfd1f;
    localparam addr_t PORT_EXT_IRQ_EN = 16'hfd2c;
    localparam addr_t PORT_SIDE_2HD   = 16'hfd34;
    localparam addr_t PORT_DRIVE_2HD  = 16'hfd35;
    localparam addr_t PORT_STAT_2HD   = 16'hfd37;

    localparam sig_id_t SIG_SUB_BUSY  = 5'd16;
    localparam sig_id_t SIG_DRQ_1M    = 5'd17;
    localparam sig_id_t SIG_DRQ_320K  = 5'd18;
    localparam sig_id_t SIG_RTC_DATA  = 5'd19;
    localparam sig_id_t SIG_RTC_BUSY  = 5'd20;

    localparam logic [BYTE_W-1:0] DRIVE_2D_RESET = 8'h80;
    localparam logic [BYTE_W-1:0] UNMAPPED_DATA  = 8'hff;

    localparam int FLAG_TX   = 0;
    localparam int FLAG_RX   = 1;
    localparam int FLAG_SYN  = 2;
    localparam int IRQ_BASE  = 2;
    localparam int FIRQ_BASE = 12;

    function automatic logic [BYTE_W-1:0] bigr_lines(
        input logic [FLAGS_W-1:0] flags,
        input logic [BYTE_W-1:0]  irq_en,
        input logic [BYTE_W-1:0]  ext_en
    );
        logic [BYTE_W-1:0] l;
        l[0] = flags[IRQ_BASE+8] & irq_en[4];
        l[1] = (flags[IRQ_BASE+1] & irq_en[7]) | flags[FIRQ_BASE+1];
        l[2] = (flags[IRQ_BASE+5] & ext_en[3]) | flags[IRQ_BASE+6];
        l[3] = flags[FIRQ_BASE+0] | flags[FIRQ_BASE+2] | flags[FIRQ_BASE+3];
        l[4] = (flags[FLAG_TX] & irq_en[1]) | (flags[FLAG_RX] & irq_en[2])
             | (flags[FLAG_SYN] & irq_en[3]);
        l[5] = flags[IRQ_BASE+2] | flags[IRQ_BASE+9];
        l[6] = flags[IRQ_BASE+4] & irq_en[5];
        l[7] = flags[IRQ_BASE+7] & irq_en[0];
        return l;
    endfunction

endpackage

@@ rtl/board_interrupt_glue_registers_core.sv @@
// ----------------------------------------------------------------------------
// Board interrupt glue registers core
// I/O register file, interrupt source flags and interrupt line mapping.
// ----------------------------------------------------------------------------
// The slave stream carries one command per transfer: an I/O write, an I/O
// read, or a source signal event (tuser holds the command). The master stream
// returns one transfer per command with the read data and the eight
// interrupt lines, recomputed from the register state after the command.
// A command waits in the input register until it advances; it is then
// decoded against the register state and its result is registered and
// presented. One command is accepted every cycle while the receiver takes
// results; the input register and the result register make a two-entry
// pipeline whose only shared resource is the register file, updated in the
// second stage. Reset clears both valid flags and the register file, except
// the 2D drive register, which comes up as 0x80. When the receiver stalls,
// the result register holds, the input register fills, and s_axis_tready
// drops until the result is taken; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "board_interrupt_glue_registers_core_defines.svh"

module board_interrupt_glue_registers_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // port_addr[15:0], wdata[23:16], signal_id[28:24], signal_mask[36:29], zero pad
    input  logic [bigr_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // cmd[1:0]
    input  logic [bigr_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // rdata[7:0], int_lines[15:8]
    output logic [bigr_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import bigr_pkg::*;

    logic                in_valid_reg;
    cmd_t                in_cmd_reg;
    addr_t               in_addr_reg;
    logic [BYTE_W-1:0]   in_wdata_reg;
    sig_id_t             in_id_reg;
    logic [BYTE_W-1:0]   in_mask_reg;

    logic                out_valid_reg;
    logic [BYTE_W-1:0]   out_rdata_reg;
    logic [BYTE_W-1:0]   out_lines_reg;

    logic [BYTE_W-1:0]   irq_en_reg, irq_en_next;
    logic [BYTE_W-1:0]   ext_en_reg, ext_en_next;
    logic [BYTE_W-1:0]   direct_reg, direct_next;
    logic [BYTE_W-1:0]   side_2d_reg, side_2d_next;
    logic [BYTE_W-1:0]   drive_2d_reg, drive_2d_next;
    logic [BYTE_W-1:0]   side_2hd_reg, side_2hd_next;
    logic [BYTE_W-1:0]   drive_2hd_reg, drive_2hd_next;
    logic [BYTE_W-1:0]   rtc_reg, rtc_next;
    logic [FLAGS_W-1:0]  flags_reg, flags_next;
    logic [MISC_W-1:0]   misc_reg, misc_next;

    logic                advance;
    logic                sig_on;
    logic [BYTE_W-1:0]   read_data;
    logic [BYTE_W-1:0]   rdata_next;
    logic [BYTE_W-1:0]   lines_next;
    logic [BYTE_W-1:0]   lines_state;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_lines_reg, out_rdata_reg};
    assign sig_on        = |(in_wdata_reg & in_mask_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_cmd_reg   <= s_axis_tuser;
            in_addr_reg  <= s_axis_tdata[15:0];
            in_wdata_reg <= s_axis_tdata[23:16];
            in_id_reg    <= s_axis_tdata[28:24];
            in_mask_reg  <= s_axis_tdata[36:29];
        end
    end

    // register file update
    always_comb
    begin
        irq_en_next    = irq_en_reg;
        ext_en_next    = ext_en_reg;
        direct_next    = direct_reg;
        side_2d_next   = side_2d_reg;
        drive_2d_next  = drive_2d_reg;
        side_2hd_next  = side_2hd_reg;
        drive_2hd_next = drive_2hd_reg;
        rtc_next       = rtc_reg;
        flags_next     = flags_reg;
        misc_next      = misc_reg;
        if (in_cmd_reg == CMD_WRITE)
        begin
            unique case (in_addr_reg)
                PORT_IRQ_EN:     irq_en_next    = in_wdata_reg;
                PORT_DIRECT:     direct_next    = in_wdata_reg;
                PORT_SIDE_2D:    side_2d_next   = in_wdata_reg;
                PORT_DRIVE_2D:   drive_2d_next  = in_wdata_reg;
                PORT_EXT_IRQ_EN: ext_en_next    = in_wdata_reg;
                PORT_SIDE_2HD:   side_2hd_next  = in_wdata_reg;
                PORT_DRIVE_2HD:  drive_2hd_next = in_wdata_reg;
                default:         ;
            endcase
        end
        else if (in_cmd_reg == CMD_SIGNAL)
        begin
            if (!in_id_reg[4])
            begin
                flags_next[in_id_reg[3:0]] = sig_on;
            end
            else
            begin
                unique case (in_id_reg) inside
                    SIG_SUB_BUSY:               misc_next[0] = sig_on;
                    SIG_DRQ_1M:                 misc_next[1] = sig_on;
                    SIG_DRQ_320K:               misc_next[2] = sig_on;
                    SIG_RTC_DATA, SIG_RTC_BUSY:
                        rtc_next = (in_wdata_reg & in_mask_reg) | (rtc_reg & ~in_mask_reg);
                    default:                    ;
                endcase
            end
        end
    end

    // read decode
    always_comb
    begin
        read_data = '0;
        unique case (in_addr_reg)
            PORT_IRQ_STAT:
            begin
                read_data[0] = flags_reg[IRQ_BASE+8];
                read_data[1] = flags_reg[IRQ_BASE+7];
                read_data[3] = flags_reg[IRQ_BASE+4];
                read_data[4] = flags_reg[IRQ_BASE+3];
                read_data[5] = flags_reg[IRQ_BASE+2];
                read_data[6] = flags_reg[IRQ_BASE+1];
                read_data[7] = flags_reg[FLAG_TX] | flags_reg[FLAG_RX] | flags_reg[FLAG_SYN];
            end
            PORT_FIRQ_STAT:
            begin
                read_data[0] = flags_reg[FIRQ_BASE+0];
                read_data[1] = flags_reg[FIRQ_BASE+1];
                read_data[7] = flags_reg[FIRQ_BASE+2];
            end
            PORT_BUSY:       read_data[7] = misc_reg[0];
            PORT_DIRECT:     read_data = direct_reg;
            PORT_RTC:        read_data = rtc_reg;
            PORT_SIDE_2D:    read_data = side_2d_reg;
            PORT_DRIVE_2D:   read_data = drive_2d_reg;
            PORT_STAT_2D:
            begin
                read_data[6] = flags_reg[IRQ_BASE+4];
                read_data[7] = misc_reg[2];
            end
            PORT_EXT_IRQ_EN:
            begin
                read_data[2] = flags_reg[IRQ_BASE+6];
                read_data[6] = flags_reg[IRQ_BASE+5];
            end
            PORT_SIDE_2HD:   read_data = side_2hd_reg;
            PORT_DRIVE_2HD:  read_data = drive_2hd_reg;
            PORT_STAT_2HD:
            begin
                read_data[6] = flags_reg[IRQ_BASE+5];
                read_data[7] = misc_reg[1];
            end
            default:         read_data = UNMAPPED_DATA;
        endcase
    end

    assign rdata_next  = (in_cmd_reg == CMD_READ) ? read_data : '0;
    assign lines_next  = bigr_lines(flags_next, irq_en_next, ext_en_next);
    assign lines_state = bigr_lines(flags_reg, irq_en_reg, ext_en_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_en_reg    <= '0;
            ext_en_reg    <= '0;
            direct_reg    <= '0;
            side_2d_reg   <= '0;
            drive_2d_reg  <= DRIVE_2D_RESET;
            side_2hd_reg  <= '0;
            drive_2hd_reg <= '0;
            rtc_reg       <= '0;
            flags_reg     <= '0;
            misc_reg      <= '0;
        end
        else if (advance)
        begin
            irq_en_reg    <= irq_en_next;
            ext_en_reg    <= ext_en_next;
            direct_reg    <= direct_next;
            side_2d_reg   <= side_2d_next;
            drive_2d_reg  <= drive_2d_next;
            side_2hd_reg  <= side_2hd_next;
            drive_2hd_reg <= drive_2hd_next;
            rtc_reg       <= rtc_next;
            flags_reg     <= flags_next;
            misc_reg      <= misc_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_rdata_reg <= rdata_next;
            out_lines_reg <= lines_next;
        end
    end

    `BIGR_ASSERT_NOW(a_result_from_pipe, $rose(out_valid_reg), $past(advance))
    `BIGR_ASSERT_NEXT(a_lines_match_state, advance, out_lines_reg == lines_state)
    `BIGR_ASSERT_NEXT(a_rdata_zero_non_read,
        advance && (in_cmd_reg != CMD_READ), out_rdata_reg == '0)
    `BIGR_ASSERT_NOW(a_drive_2d_write_only, !$stable(drive_2d_reg),
        $past(advance) && ($past(in_cmd_reg) == CMD_WRITE)
        && ($past(in_addr_reg) == PORT_DRIVE_2D))

endmodule

@@ verif/board_interrupt_glue_registers_core_test.sv @@
// ----------------------------------------------------------------------------
// Board interrupt glue registers core testbench
// Drives I/O writes, I/O reads and source signal events into the slave
// stream: first a table of directed transfers, then random traffic, mostly
// to mapped ports and known signals. A register and flag model predicts the
// read data and interrupt lines of each accepted command (typed directed
// rows give their own); results are compared in order. Both streams idle
// in random bursts; the receiver holds off once long enough to stall input.
// ----------------------------------------------------------------------------
module board_interrupt_glue_registers_core_test;

    import bigr_pkg::*;

    localparam int   RANDOM_ITEMS = 1000;
    localparam int   QUIET_FROM   = 850;
    localparam int   HOLD_AT      = 300;
    localparam int   HOLD_CYCLES  = 60;
    localparam int   CYCLE_LIMIT  = 200000;
    localparam cmd_t CMD_NONE     = 2'd3;

    typedef logic [BYTE_W-1:0] byte_t;

    typedef struct packed {
        byte_t rdata;
        byte_t int_lines;
    } glue_result_t;

    typedef struct packed {
        cmd_t    cmd;
        addr_t   port_addr;
        byte_t   wdata;
        sig_id_t signal_id;
        byte_t   signal_mask;
        logic    typed;
        byte_t   rdata;
        byte_t   int_lines;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic [CMD_W-1:0]     s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    glue_result_t pending_results[$];
    int           fail_count = 0;
    int           cycle_count = 0;
    logic         idle_on = 1'b1;
    logic         hold_req = 1'b0;

    byte_t            irq_en_q, ext_en_q, direct_q, side_2d_q, drive_2d_q;
    byte_t            side_2hd_q, drive_2hd_q, rtc_q;
    logic [FLAGS_W-1:0] src_q;
    logic [MISC_W-1:0]  misc_q;

    addr_t mapped_ports [14] = '{
        PORT_IRQ_EN, PORT_IRQ_STAT, PORT_FIRQ_STAT, PORT_BUSY, PORT_DIRECT, PORT_RTC,
        PORT_SIDE_2D, PORT_DRIVE_2D, PORT_STAT_2D, PORT_EXT_IRQ_EN, PORT_SIDE_2HD,
        PORT_DRIVE_2HD, PORT_STAT_2HD, 16'hfd36
    };

    stim_row_t directed_rows [25] = '{
        '{CMD_READ,   PORT_DRIVE_2D,   8'h00, 5'd0,         8'h00, 1'b1, 8'h80, 8'h00},
        '{CMD_READ,   16'h0060,        8'h00, 5'd0,         8'h00, 1'b1, 8'hff, 8'h00},
        '{CMD_READ,   16'hfd36,        8'h00, 5'd0,         8'h00, 1'b1, 8'hff, 8'h00},
        '{CMD_READ,   16'hffff,        8'hff, 5'd31,        8'hff, 1'b1, 8'hff, 8'h00},
        '{CMD_NONE,   16'hffff,        8'hff, 5'd31,        8'hff, 1'b1, 8'h00, 8'h00},
        '{CMD_WRITE,  PORT_IRQ_EN,     8'hff, 5'd0,         8'h00, 1'b1, 8'h00, 8'h00},
        '{CMD_WRITE,  PORT_EXT_IRQ_EN, 8'hff, 5'd0,         8'h00, 1'b1, 8'h00, 8'h00},
        '{CMD_WRITE,  PORT_DIRECT,     8'hff, 5'd0,         8'h00, 1'b1, 8'h00, 8'h00},
        '{CMD_WRITE,  PORT_DRIVE_2D,   8'h00, 5'd0,         8'h00, 1'b1, 8'h00, 8'h00},
        '{CMD_WRITE,  16'h0000,        8'hff, 5'd0,         8'h00, 1'b1, 8'h00, 8'h00},
        '{CMD_SIGNAL, 16'h0000,        8'hff, 5'd0,         8'h01, 1'b0, 8'h00, 8'h00},
        '{CMD_SIGNAL, 16'h0000,        8'hff, 5'd10,        8'hff, 1'b0, 8'h00, 8'h00},
        '{CMD_SIGNAL, 16'h0000,        8'h80, 5'd13,        8'h80, 1'b0, 8'h00, 8'h00},
        '{CMD_SIGNAL, 16'h0000,        8'h01, 5'd15,        8'h01, 1'b0, 8'h00, 8'h00},
        '{CMD_SIGNAL, 16'hffff,        8'hff, 5'd31,        8'hff, 1'b0, 8'h00, 8'h00},
        '{CMD_SIGNAL, 16'h0000,        8'hff, SIG_SUB_BUSY, 8'h80, 1'b0, 8'h00, 8'h00},
        '{CMD_SIGNAL, 16'h0000,        8'h01, SIG_DRQ_1M,   8'h01, 1'b0, 8'h00, 8'h00},
        '{CMD_SIGNAL, 16'h0000,        8'h02, SIG_DRQ_320K, 8'h02, 1'b0, 8'h00, 8'h00},
        '{CMD_SIGNAL, 16'h0000,        8'ha5, SIG_RTC_DATA, 8'hf0, 1'b0, 8'h00, 8'h00},
        '{CMD_SIGNAL, 16'h0000,        8'h0f, SIG_RTC_BUSY, 8'h0f, 1'b0, 8'h00, 8'h00},
        '{CMD_READ,   PORT_IRQ_STAT,   8'h00, 5'd0,         8'h00, 1'b0, 8'h00, 8'h00},
        '{CMD_READ,   PORT_FIRQ_STAT,  8'h00, 5'd0,         8'h00, 1'b0, 8'h00, 8'h00},
        '{CMD_READ,   PORT_BUSY,       8'h00, 5'd0,         8'h00, 1'b0, 8'h00, 8'h00},
        '{CMD_READ,   PORT_RTC,        8'h00, 5'd0,         8'h00, 1'b0, 8'h00, 8'h00},
        '{CMD_SIGNAL, 16'h0000,        8'hff, 5'd10,        8'h00, 1'b0, 8'h00, 8'h00}
    };

    board_interrupt_glue_registers_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 clk = ~clk;

    task automatic glue_predict(input stim_row_t r, output glue_result_t res);
        logic  on;
        byte_t rd;
        byte_t ln;
        rd = 8'h00;
        on = |(r.wdata & r.signal_mask);
        case (r.cmd)
            CMD_WRITE:
            begin
                case (r.port_addr)
                    PORT_IRQ_EN:     irq_en_q = r.wdata;
                    PORT_DIRECT:     direct_q = r.wdata;
                    PORT_SIDE_2D:    side_2d_q = r.wdata;
                    PORT_DRIVE_2D:   drive_2d_q = r.wdata;
                    PORT_EXT_IRQ_EN: ext_en_q = r.wdata;
                    PORT_SIDE_2HD:   side_2hd_q = r.wdata;
                    PORT_DRIVE_2HD:  drive_2hd_q = r.wdata;
                    default:         ;
                endcase
            end
            CMD_READ:
            begin
                case (r.port_addr)
                    PORT_IRQ_STAT:   rd = {|src_q[2:0], src_q[3], src_q[4], src_q[5],
                                           src_q[6], 1'b0, src_q[9], src_q[10]};
                    PORT_FIRQ_STAT:  rd = {src_q[14], 5'b0, src_q[13], src_q[12]};
                    PORT_BUSY:       rd = {misc_q[0], 7'b0};
                    PORT_DIRECT:     rd = direct_q;
                    PORT_RTC:        rd = rtc_q;
                    PORT_SIDE_2D:    rd = side_2d_q;
                    PORT_DRIVE_2D:   rd = drive_2d_q;
                    PORT_STAT_2D:    rd = {misc_q[2], src_q[6], 6'b0};
                    PORT_EXT_IRQ_EN: rd = {1'b0, src_q[7], 3'b0, src_q[8], 2'b0};
                    PORT_SIDE_2HD:   rd = side_2hd_q;
                    PORT_DRIVE_2HD:  rd = drive_2hd_q;
                    PORT_STAT_2HD:   rd = {misc_q[1], src_q[7], 6'b0};
                    default:         rd = 8'hff;
                endcase
            end
            CMD_SIGNAL:
            begin
                if (r.signal_id < 5'd16)
                    src_q[r.signal_id[3:0]] = on;
                else if (r.signal_id < SIG_RTC_DATA)
                    misc_q[r.signal_id - SIG_SUB_BUSY] = on;
                else if (r.signal_id <= SIG_RTC_BUSY)
                    rtc_q = (r.wdata & r.signal_mask) | (rtc_q & ~r.signal_mask);
            end
            default: ;
        endcase
        ln[0] = src_q[10] & irq_en_q[4];
        ln[1] = (src_q[3] & irq_en_q[7]) | src_q[13];
        ln[2] = (src_q[7] & ext_en_q[3]) | src_q[8];
        ln[3] = src_q[12] | src_q[14] | src_q[15];
        ln[4] = (src_q[0] & irq_en_q[1]) | (src_q[1] & irq_en_q[2]) | (src_q[2] & irq_en_q[3]);
        ln[5] = src_q[4] | src_q[11];
        ln[6] = src_q[6] & irq_en_q[5];
        ln[7] = src_q[9] & irq_en_q[0];
        res.rdata = rd;
        res.int_lines = ln;
    endtask

    task automatic random_row(output stim_row_t r);
        int pick;
        pick = $urandom_range(0, 99);
        r = '0;
        r.cmd = pick < 35 ? CMD_WRITE : pick < 70 ? CMD_READ : pick < 95 ? CMD_SIGNAL : CMD_NONE;
        pick = $urandom_range(0, 9);
        if (pick < 8)
            r.port_addr = mapped_ports[$urandom_range(0, 13)];
        else if (pick == 8)
            r.port_addr = 16'h0060;
        else
            r.port_addr = addr_t'($urandom);
        r.wdata = byte_t'($urandom);
        if ($urandom_range(0, 9) == 0)
            r.signal_id = sig_id_t'($urandom_range(21, 31));
        else
            r.signal_id = sig_id_t'($urandom_range(0, 20));
        case ($urandom_range(0, 3))
            0, 1:    r.signal_mask = 8'hff;
            2:       r.signal_mask = byte_t'($urandom);
            default: r.signal_mask = 8'h01 << $urandom_range(0, 7);
        endcase
    endtask

    task automatic send_command(input stim_row_t r);
        glue_result_t res;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b0, r.signal_mask, r.signal_id, r.wdata, r.port_addr};
        s_axis_tuser  <= r.cmd;
        do @(posedge clk); while (!s_axis_tready);
        glue_predict(r, res);
        if (r.typed)
            pending_results.push_back({r.rdata, r.int_lines});
        else
            pending_results.push_back(res);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        glue_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected transfer: rdata %02h int_lines %02h",
                       m_axis_tdata[7:0], m_axis_tdata[15:8]);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tdata[7:0] !== want.rdata)
                begin
                    $error("rdata: expected %02h, actual %02h", want.rdata, m_axis_tdata[7:0]);
                    fail_count++;
                end
                if (m_axis_tdata[15:8] !== want.int_lines)
                begin
                    $error("int_lines: expected %02h, actual %02h",
                           want.int_lines, m_axis_tdata[15:8]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int   hold_left;
        int   gap_left;
        logic hold_done;
        hold_left = 0;
        gap_left = 0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else if (gap_left > 0)
            begin
                gap_left--;
                m_axis_tready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                gap_left = $urandom_range(1, 9) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin
        stim_row_t r;
        irq_en_q = '0;
        ext_en_q = '0;
        direct_q = '0;
        side_2d_q = '0;
        drive_2d_q = DRIVE_2D_RESET;
        side_2hd_q = '0;
        drive_2hd_q = '0;
        rtc_q = '0;
        src_q = '0;
        misc_q = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed_rows[i])
            send_command(directed_rows[i]);
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            idle_on = (n < QUIET_FROM) && ((n / 120) % 3 != 2);
            if (n == HOLD_AT)
                hold_req = 1'b1;
            random_row(r);
            send_command(r);
        end
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/bigr_pkg.sv
rtl/board_interrupt_glue_registers_core.sv
verif/board_interrupt_glue_registers_core_test.sv
